### rtl/spr_pkg.sv
package spr_pkg;

  localparam int GUARD = 16;
  localparam int XW = 51;
  localparam int ZW = 41;
  localparam int AW = 34;
  localparam int QW = 11;
  localparam logic [31:0] KINV = 32'd2608131496;
  localparam logic [63:0] RECIP90 = 64'd47721859;
  localparam logic [63:0] Q56_ONE = 64'd1 << 56;

  typedef struct packed {
    logic              kind;
    logic              byp;
    logic [31:0]       byp_d;
    logic              th90;
    logic              dxneg;
    logic              dyneg;
    logic [1:0]        q;
    logic signed [30:0] fx;
    logic signed [30:0] fy;
  } sb_t;

  typedef struct packed {
    logic               vec;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } cell_t;

  // Unsigned quotient by restoring long division; the divisor stays below 2^63.
  function automatic logic [63:0] spr_div(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int j = 63; j >= 0; j--) begin
      r = {r[62:0], a[j]};
      if (r >= b) begin
        r = r - b;
        q[j] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] spr_mod(input logic [63:0] a, input logic [63:0] b);
    return a - spr_div(a, b) * b;
  endfunction

  function automatic logic [63:0] spr_atan_inv(input logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] term;
    p = spr_div(Q56_ONE, n);
    sum = '0;
    k = '0;
    while (p != 0) begin
      term = spr_div(p, 2 * k + 1);
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      p = spr_div(p, n * n);
      k = k + 1;
    end
    return sum;
  endfunction

  function automatic logic [63:0] spr_atan_pow2(input int i);
    logic [63:0] sum;
    logic [63:0] k;
    logic [63:0] term;
    int sh;
    sum = '0;
    k = '0;
    sh = i;
    while (sh <= 56) begin
      term = spr_div(Q56_ONE >> sh, 2 * k + 1);
      if (k[0]) sum = sum - term;
      else sum = sum + term;
      sh = sh + 2 * i;
      k = k + 1;
    end
    return sum;
  endfunction

  // Arctangent of 2^-i in degrees with 32 fraction bits, rounded to nearest.
  function automatic logic [63:0] spr_atan(input int i);
    logic [63:0] qp;
    logic [63:0] n;
    logic [63:0] q;
    logic [63:0] r;
    qp = 4 * spr_atan_inv(64'd5) - spr_atan_inv(64'd239);
    if (i == 0) return 64'd45 << 32;
    n = spr_atan_pow2(i) * 64'd45;
    q = spr_div(n, qp);
    r = spr_mod(n, qp);
    for (int b = 0; b < 32; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= qp) begin
        r = r - qp;
        q = q | 64'd1;
      end
    end
    r = r << 1;
    if (r >= qp) q = q + 1;
    return q;
  endfunction

endpackage

### rtl/spr_pre.sv
module spr_pre
  import spr_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               gauss_i,
  input  logic               vld_i,
  input  logic               kind_i,
  input  logic signed [30:0] from_x_i,
  input  logic signed [30:0] from_y_i,
  input  logic signed [30:0] to_x_i,
  input  logic signed [30:0] to_y_i,
  input  logic [31:0]        dist_i,
  input  logic [24:0]        bearing_i,
  output logic               vld_o,
  output sb_t                sb_o,
  output cell_t              c_o
);

  localparam int F = ANGLE_FRAC_BITS;

  logic               vld1_q;
  logic               kind1_q;
  logic signed [30:0] fx1_q, fy1_q;
  logic signed [31:0] dx1_q, dy1_q;
  logic [31:0]        dist1_q;
  logic [24:0]        b1_q;
  logic [QW-1:0]      qd1_q;
  logic [63:0]        prod;

  logic               vld2_q;
  sb_t                sb2_d, sb2_q;
  cell_t              c2_d, c2_q;
  logic [31:0]        ax, ay;
  logic [17:0]        vr;
  logic [ZW-1:0]      r;

  assign prod = 64'(bearing_i[24:F]) * RECIP90;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind1_q <= kind_i;
      fx1_q   <= from_x_i;
      fy1_q   <= from_y_i;
      dx1_q   <= 32'(to_x_i) - 32'(from_x_i);
      dy1_q   <= 32'(to_y_i) - 32'(from_y_i);
      dist1_q <= dist_i;
      b1_q    <= bearing_i;
      qd1_q   <= prod[32 +: QW];
      sb2_q   <= sb2_d;
      c2_q    <= c2_d;
    end
  end

  always_comb begin
    ax = dx1_q[31] ? 32'(-dx1_q) : 32'(dx1_q);
    ay = dy1_q[31] ? 32'(-dy1_q) : 32'(dy1_q);
    vr = 18'(b1_q[24:F]) - 18'(qd1_q) * 18'd90;
    r = ZW'({vr[6:0], b1_q[F-1:0]});
    sb2_d.kind  = kind1_q;
    sb2_d.byp   = (ax == '0) || (ay == '0);
    sb2_d.byp_d = (ax == '0) ? ay : ax;
    sb2_d.th90  = (ax != '0);
    sb2_d.dxneg = dx1_q[31];
    sb2_d.dyneg = dy1_q[31];
    sb2_d.q     = qd1_q[1:0] + {gauss_i, 1'b0};
    sb2_d.fx    = fx1_q;
    sb2_d.fy    = fy1_q;
    if (!kind1_q) begin
      c2_d.vec = 1'b1;
      c2_d.x   = XW'(ay) <<< GUARD;
      c2_d.y   = XW'(ax) <<< GUARD;
      c2_d.z   = '0;
    end else begin
      c2_d.vec = 1'b0;
      c2_d.x   = XW'(dist1_q) <<< GUARD;
      c2_d.y   = '0;
      c2_d.z   = r << (32 - F);
    end
  end

  assign vld_o = vld2_q;
  assign sb_o  = sb2_q;
  assign c_o   = c2_q;

endmodule

### rtl/spr_cell.sv
module spr_cell
  import spr_pkg::*;
#(
  parameter int I = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  vld_i,
  input  sb_t   sb_i,
  input  cell_t c_i,
  output logic  vld_o,
  output sb_t   sb_o,
  output cell_t c_o
);

  localparam logic [63:0] ATAN64 = spr_atan(I);
  localparam logic signed [ZW-1:0] ATAN = ZW'(ATAN64);

  logic                 vld_q;
  sb_t                  sb_q;
  cell_t                c_d, c_q;
  logic                 neg;
  logic signed [XW-1:0] xs, ys;

  always_comb begin
    neg = c_i.vec ? !c_i.y[XW-1] : c_i.z[ZW-1];
    xs  = c_i.x >>> I;
    ys  = c_i.y >>> I;
    c_d.vec = c_i.vec;
    if (neg) begin
      c_d.x = c_i.x + ys;
      c_d.y = c_i.y - xs;
      c_d.z = c_i.z + ATAN;
    end else begin
      c_d.x = c_i.x - ys;
      c_d.y = c_i.y + xs;
      c_d.z = c_i.z - ATAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q <= sb_i;
      c_q  <= c_d;
    end
  end

  assign vld_o = vld_q;
  assign sb_o  = sb_q;
  assign c_o   = c_q;

endmodule

### rtl/spr_post.sv
module spr_post
  import spr_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               gauss_i,
  input  logic               vld_i,
  input  sb_t                sb_i,
  input  cell_t              c_i,
  output logic               vld_o,
  output logic [31:0]        dist_o,
  output logic [24:0]        bearing_o,
  output logic [30:0]        point_x_o,
  output logic [30:0]        point_y_o,
  output logic               overflow_o
);

  localparam int F = ANGLE_FRAC_BITS;
  localparam logic [AW-1:0] QUARTER = AW'(90) << F;
  localparam logic [AW-1:0] HALF = AW'(180) << F;
  localparam logic [AW-1:0] FULL = AW'(360) << F;
  localparam logic [ZW-1:0] ZRND = ZW'(1) << (31 - F);
  localparam logic signed [37:0] PMAX = 38'sd1073741823;
  localparam logic signed [37:0] PMIN = -38'sd1073741824;

  logic               vld1_q, vld2_q, vld3_q;
  sb_t                sb1_q, sb2_q, sb3_q;
  logic [XW-1:0]      mx1_d, my1_d, mx1_q, my1_q;
  logic               xn1_q, yn1_q, xn2_q, yn2_q;
  logic [ZW-1:0]      zc, zr;
  logic [AW-1:0]      th1_d, th1_q, th2_q, th3_q;
  logic [63:0]        xl2_q, xh2_q, yl2_q, yh2_q;
  logic [63:0]        mxs, mys;
  logic [35:0]        cm, sm;
  logic signed [36:0] c3_q, s3_q;

  logic [AW-1:0]      thv, b0, b1, b2;
  logic signed [36:0] ddx, ddy;
  logic signed [37:0] px, py;

  always_comb begin
    if (c_i.x[XW-1]) mx1_d = sb_i.kind ? XW'(-c_i.x) : '0;
    else mx1_d = XW'(c_i.x);
    my1_d = c_i.y[XW-1] ? XW'(-c_i.y) : XW'(c_i.y);
    zc = c_i.z[ZW-1] ? '0 : ZW'(c_i.z);
    zr = (zc + ZRND) >> (32 - F);
    th1_d = (zr > ZW'(QUARTER)) ? QUARTER : AW'(zr);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_comb begin
    mxs = xh2_q + (xl2_q >> 32) + 64'(1 << (GUARD - 1));
    mys = yh2_q + (yl2_q >> 32) + 64'(1 << (GUARD - 1));
    cm = mxs[GUARD +: 36];
    sm = mys[GUARD +: 36];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb1_q <= sb_i;
      mx1_q <= mx1_d;
      my1_q <= my1_d;
      xn1_q <= sb_i.kind && c_i.x[XW-1];
      yn1_q <= c_i.y[XW-1];
      th1_q <= th1_d;
      sb2_q <= sb1_q;
      xn2_q <= xn1_q;
      yn2_q <= yn1_q;
      th2_q <= th1_q;
      xl2_q <= 64'(mx1_q[31:0]) * 64'(KINV);
      xh2_q <= 64'(mx1_q[XW-1:32]) * 64'(KINV);
      yl2_q <= 64'(my1_q[31:0]) * 64'(KINV);
      yh2_q <= 64'(my1_q[XW-1:32]) * 64'(KINV);
      sb3_q <= sb2_q;
      th3_q <= th2_q;
      c3_q  <= xn2_q ? -$signed({1'b0, cm}) : $signed({1'b0, cm});
      s3_q  <= yn2_q ? -$signed({1'b0, sm}) : $signed({1'b0, sm});
    end
  end

  always_comb begin
    if (sb3_q.byp) thv = sb3_q.th90 ? QUARTER : '0;
    else thv = th3_q;
    if (!sb3_q.dxneg) b0 = sb3_q.dyneg ? HALF - thv : thv;
    else b0 = sb3_q.dyneg ? HALF + thv : FULL - thv;
    b1 = (b0 == FULL) ? '0 : b0;
    if (gauss_i) b2 = (b1 >= HALF) ? b1 - HALF : b1 + HALF;
    else b2 = b1;

    unique case (sb3_q.q)
      2'd0: begin ddx = s3_q;  ddy = c3_q;  end
      2'd1: begin ddx = c3_q;  ddy = -s3_q; end
      2'd2: begin ddx = -s3_q; ddy = -c3_q; end
      default: begin ddx = -c3_q; ddy = s3_q; end
    endcase
    px = 38'(sb3_q.fx) + 38'(ddx);
    py = 38'(sb3_q.fy) + 38'(ddy);

    dist_o = '0;
    bearing_o = '0;
    point_x_o = '0;
    point_y_o = '0;
    overflow_o = 1'b0;
    if (!sb3_q.kind) begin
      if (sb3_q.byp) dist_o = sb3_q.byp_d;
      else if (c3_q > 37'sh0FFFFFFFF) dist_o = '1;
      else dist_o = c3_q[31:0];
      bearing_o = b2[24:0];
    end else begin
      if (px > PMAX) point_x_o = PMAX[30:0];
      else if (px < PMIN) point_x_o = PMIN[30:0];
      else point_x_o = px[30:0];
      if (py > PMAX) point_y_o = PMAX[30:0];
      else if (py < PMIN) point_y_o = PMIN[30:0];
      else point_y_o = py[30:0];
      overflow_o = (px > PMAX) || (px < PMIN) || (py > PMAX) || (py < PMIN);
    end
  end

  assign vld_o = vld3_q;

endmodule

### rtl/survey_polar_rect_converter_core.sv
// Surveying coordinate converter: tuser 0 turns two points into distance and
// azimuth, tuser 1 turns a station, distance and azimuth into a target point.
// It takes one word per clock cycle unless the master side stalls it; each
// result passes through two setup stages, a row of CORDIC cells, one per
// iteration, three gain and mapping stages and an output register.
// Backpressure on the master side stalls the whole pipe; cfg_we_i writes the
// south reference bit; the user must see that it is used only while the pipe
// is empty, since the block itself does not enforce this.
module survey_polar_rect_converter_core
  import spr_pkg::*;
#(
  parameter int CORDIC_STAGES = 24,
  parameter int ANGLE_FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  input  logic         s_tvalid,
  output logic         s_tready,
  // from_x, from_y, to_x, to_y, dist_in, bearing_in, zero pad
  input  logic [183:0] s_tdata,
  // kind
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // dist_out, bearing_out, point_x, point_y, overflow
  output logic [119:0] m_tdata
);

  logic   gauss_q;
  logic   en;
  logic   vld [CORDIC_STAGES+1];
  sb_t    sb  [CORDIC_STAGES+1];
  cell_t  cc  [CORDIC_STAGES+1];
  logic   pvld;
  logic [31:0] dist_mm;
  logic [24:0] bearing;
  logic [30:0] px, py;
  logic        ovf;
  logic        out_vld_q;
  logic [119:0] out_q;

  assign en = !out_vld_q || m_tready;
  assign s_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gauss_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) gauss_q <= cfg_wdata_i;
      if (en) out_vld_q <= pvld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) out_q <= {ovf, py, px, bearing, dist_mm};
  end

  spr_pre #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pre (
    .clk_i, .rst_ni,
    .en_i      (en),
    .gauss_i   (gauss_q),
    .vld_i     (s_tvalid),
    .kind_i    (s_tuser),
    .from_x_i  (s_tdata[30:0]),
    .from_y_i  (s_tdata[61:31]),
    .to_x_i    (s_tdata[92:62]),
    .to_y_i    (s_tdata[123:93]),
    .dist_i    (s_tdata[155:124]),
    .bearing_i (s_tdata[180:156]),
    .vld_o     (vld[0]),
    .sb_o      (sb[0]),
    .c_o       (cc[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    spr_cell #(.I(i)) u_cell (
      .clk_i, .rst_ni,
      .en_i  (en),
      .vld_i (vld[i]),
      .sb_i  (sb[i]),
      .c_i   (cc[i]),
      .vld_o (vld[i+1]),
      .sb_o  (sb[i+1]),
      .c_o   (cc[i+1])
    );
  end

  spr_post #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_post (
    .clk_i, .rst_ni,
    .en_i       (en),
    .gauss_i    (gauss_q),
    .vld_i      (vld[CORDIC_STAGES]),
    .sb_i       (sb[CORDIC_STAGES]),
    .c_i        (cc[CORDIC_STAGES]),
    .vld_o      (pvld),
    .dist_o     (dist_mm),
    .bearing_o  (bearing),
    .point_x_o  (px),
    .point_y_o  (py),
    .overflow_o (ovf)
  );

  assign m_tvalid = out_vld_q;
  assign m_tdata  = out_q;

endmodule

### tb/survey_polar_rect_converter_core_tb.sv
module survey_polar_rect_converter_core_tb;

  localparam int STAGES = 24;
  localparam int FRAC = 16;
  localparam int LATENCY = STAGES + 6;
  localparam longint FULL_TURN = 64'd360 << FRAC;
  localparam longint HALF_TURN = 64'd180 << FRAC;
  localparam longint QUARTER_TURN = 64'd90 << FRAC;
  localparam longint CMAX = 64'sd1073741823;
  localparam longint CMIN = -64'sd1073741824;
  localparam logic KIND_INVERSE = 1'b0;
  localparam logic KIND_FORWARD = 1'b1;
  localparam longint CYCLE_LIMIT = 64'd400000;

  typedef struct packed {
    logic        ovf;
    logic [30:0] py;
    logic [30:0] px;
    logic [24:0] bearing;
    logic [31:0] dist_mm;
  } conv_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;
  logic s_tvalid;
  logic s_tready;
  logic [183:0] s_tdata;
  logic s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [119:0] m_tdata;

  survey_polar_rect_converter_core uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  conv_result_t expected_q[$];
  longint atan_tab[32];
  bit south_ref;
  int errors;
  longint cycles;
  bit rx_idle_en;
  int rx_hold;
  bit tx_idle_en;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint series_inv(longint unsigned n);
    longint unsigned p, sum, k, term;
    p = (64'd1 << 56) / n;
    sum = 0;
    k = 0;
    while (p != 0) begin
      term = p / (2 * k + 1);
      if (k[0]) sum -= term; else sum += term;
      p = p / (n * n);
      k++;
    end
    return sum;
  endfunction

  function automatic longint series_pow2(int i);
    longint unsigned sum, k, term;
    int sh;
    sum = 0;
    k = 0;
    sh = i;
    while (sh <= 56) begin
      term = ((64'd1 << 56) >> sh) / (2 * k + 1);
      if (k[0]) sum -= term; else sum += term;
      sh += 2 * i;
      k++;
    end
    return sum;
  endfunction

  task automatic build_atan_table();
    longint unsigned qp, n, q, r;
    qp = 4 * series_inv(5) - series_inv(239);
    atan_tab[0] = 64'd45 << 32;
    for (int i = 1; i < 32; i++) begin
      n = series_pow2(i) * 45;
      q = n / qp;
      r = n % qp;
      for (int b = 0; b < 32; b++) begin
        r = r << 1;
        q = q << 1;
        if (r >= qp) begin
          r -= qp;
          q |= 1;
        end
      end
      r = r << 1;
      if (r >= qp) q++;
      atan_tab[i] = q;
    end
  endtask

  function automatic longint unsigned gain_mag(longint unsigned m);
    longint unsigned lo, hi;
    lo = (m & 64'hFFFFFFFF) * 64'd2608131496;
    hi = (m >> 32) * 64'd2608131496 + (lo >> 32);
    return (hi + (64'd1 << 15)) >> 16;
  endfunction

  function automatic longint gain_signed(longint v);
    if (v < 0) return -longint'(gain_mag(-v));
    return gain_mag(v);
  endfunction

  function automatic longint clamp_coord(longint v, ref logic ovf);
    if (v > CMAX) begin
      ovf = 1'b1;
      return CMAX;
    end
    if (v < CMIN) begin
      ovf = 1'b1;
      return CMIN;
    end
    return v;
  endfunction

  function automatic conv_result_t convert(logic kind, logic signed [30:0] fx31,
      logic signed [30:0] fy31, logic signed [30:0] tx31, logic signed [30:0] ty31,
      logic [31:0] din, logic [24:0] bin);
    conv_result_t res;
    longint fx, fy, dx, dy, ax, ay, th, b, x, y, z, xs, ys, c, s, q, r, ddx, ddy;
    longint unsigned d;
    logic ovf;
    res = '0;
    ovf = 1'b0;
    fx = fx31;
    fy = fy31;
    if (kind == KIND_INVERSE) begin
      dx = longint'(tx31) - fx;
      dy = longint'(ty31) - fy;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax == 0) begin
        d = ay;
        th = 0;
      end else if (ay == 0) begin
        d = ax;
        th = QUARTER_TURN;
      end else begin
        x = ay << 16;
        y = ax << 16;
        z = 0;
        for (int i = 0; i < STAGES; i++) begin
          xs = shr(x, i);
          ys = shr(y, i);
          if (y >= 0) begin
            x += ys; y -= xs; z += atan_tab[i];
          end else begin
            x -= ys; y += xs; z -= atan_tab[i];
          end
        end
        d = gain_mag(x < 0 ? 0 : x);
        if (z < 0) z = 0;
        th = (z + (64'sd1 << (31 - FRAC))) >>> (32 - FRAC);
        if (th > QUARTER_TURN) th = QUARTER_TURN;
      end
      if (dx >= 0) b = (dy >= 0) ? th : HALF_TURN - th;
      else b = (dy < 0) ? HALF_TURN + th : FULL_TURN - th;
      b = b % FULL_TURN;
      if (south_ref) b = (b + FULL_TURN - HALF_TURN) % FULL_TURN;
      res.dist_mm = d > 64'hFFFFFFFF ? 32'hFFFFFFFF : d[31:0];
      res.bearing = b[24:0];
    end else begin
      b = longint'(bin) % FULL_TURN;
      if (south_ref) b = (b + HALF_TURN) % FULL_TURN;
      q = b / QUARTER_TURN;
      r = b - q * QUARTER_TURN;
      z = r << (32 - FRAC);
      x = longint'(din) << 16;
      y = 0;
      for (int i = 0; i < STAGES; i++) begin
        xs = shr(x, i);
        ys = shr(y, i);
        if (z >= 0) begin
          x -= ys; y += xs; z -= atan_tab[i];
        end else begin
          x += ys; y -= xs; z += atan_tab[i];
        end
      end
      c = gain_signed(x);
      s = gain_signed(y);
      case (q & 3)
        0: begin ddx = s; ddy = c; end
        1: begin ddx = c; ddy = -s; end
        2: begin ddx = -s; ddy = -c; end
        default: begin ddx = -c; ddy = s; end
      endcase
      res.px = 31'(clamp_coord(fx + ddx, ovf));
      res.py = 31'(clamp_coord(fy + ddy, ovf));
      res.ovf = ovf;
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("survey_polar_rect_converter_core_tb: FAIL");
      $finish;
    end
  end

  // Receiver: random ready bursts, plus a long hold-off when requested.
  initial begin
    int n;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold = rx_hold - 1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n - 1) @(posedge clk_i);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    conv_result_t got, want;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata;
      if (expected_q.size() == 0) begin
        $error("word with no expectation waiting: %h", m_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.dist_mm !== want.dist_mm) begin
          $error("dist_out expected %0d actual %0d", want.dist_mm, got.dist_mm);
          errors++;
        end
        if (got.bearing !== want.bearing) begin
          $error("bearing_out expected %0d actual %0d", want.bearing, got.bearing);
          errors++;
        end
        if (got.px !== want.px) begin
          $error("point_x expected %0d actual %0d", $signed(want.px), $signed(got.px));
          errors++;
        end
        if (got.py !== want.py) begin
          $error("point_y expected %0d actual %0d", $signed(want.py), $signed(got.py));
          errors++;
        end
        if (got.ovf !== want.ovf) begin
          $error("overflow expected %0d actual %0d", want.ovf, got.ovf);
          errors++;
        end
      end
    end
  end

  task automatic send_word(logic kind, logic [30:0] fx, logic [30:0] fy, logic [30:0] tx,
      logic [30:0] ty, logic [31:0] din, logic [24:0] bin);
    int n;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 12);
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {3'b0, bin, din, ty, tx, fy, fx};
    expected_q.push_back(convert(kind, fx, fy, tx, ty, din, bin));
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic set_reference(bit south);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= south;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    south_ref = south;
  endtask

  function automatic logic [30:0] rand_coord(int mode);
    case (mode)
      0: return 31'($urandom);
      1: return 31'($signed($urandom_range(0, 2000000)) - 1000000);
      2: return $urandom_range(0, 1) ? 31'h3FFFFFFF : 31'h40000000;
      default: return 31'($signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  task automatic random_word();
    logic [30:0] fx, fy, tx, ty;
    logic [31:0] din;
    logic [24:0] bin;
    int m;
    m = $urandom_range(0, 3);
    fx = rand_coord(m);
    fy = rand_coord($urandom_range(0, 3));
    tx = $urandom_range(0, 7) == 0 ? fx : rand_coord($urandom_range(0, 3));
    ty = $urandom_range(0, 7) == 0 ? fy : rand_coord(m);
    case ($urandom_range(0, 3))
      0: din = $urandom;
      1: din = $urandom_range(0, 100000);
      2: din = $urandom_range(0, 2000000000);
      default: din = $urandom_range(0, 10);
    endcase
    case ($urandom_range(0, 5))
      0: bin = 25'($urandom);
      1: bin = 25'(QUARTER_TURN * $urandom_range(0, 4));
      default: bin = 25'($urandom_range(0, 23592959));
    endcase
    send_word(1'($urandom_range(0, 1)), fx, fy, tx, ty, din, bin);
  endtask

  task automatic test_directed();
    send_word(KIND_INVERSE, 31'd5, 31'd7, 31'd5, 31'd7, '0, '0);
    send_word(KIND_INVERSE, 31'd0, 31'd0, 31'd0, 31'd1000, '0, '0);
    send_word(KIND_INVERSE, 31'd0, 31'd0, 31'd1000, 31'd0, '0, '0);
    send_word(KIND_INVERSE, 31'd0, 31'd0, 31'd0, -31'sd1000, '0, '0);
    send_word(KIND_INVERSE, 31'd0, 31'd0, -31'sd1000, 31'd0, '0, '0);
    send_word(KIND_INVERSE, 31'd0, 31'd0, 31'd300, 31'd400, '0, '0);
    send_word(KIND_INVERSE, 31'd0, 31'd0, -31'sd300, 31'd400, '0, '0);
    send_word(KIND_INVERSE, 31'd0, 31'd0, -31'sd300, -31'sd400, '0, '0);
    send_word(KIND_INVERSE, 31'd0, 31'd0, 31'd300, -31'sd400, '0, '0);
    send_word(KIND_INVERSE, 31'h40000000, 31'h40000000, 31'h3FFFFFFF, 31'h3FFFFFFF, '0, '0);
    send_word(KIND_INVERSE, 31'h3FFFFFFF, 31'h40000000, 31'h40000000, 31'h3FFFFFFF, '0, '0);
    send_word(KIND_INVERSE, 31'h40000000, 31'h3FFFFFFF, 31'h40000000, 31'h40000000, '0, '0);
    send_word(KIND_FORWARD, 31'd0, 31'd0, '0, '0, 32'd1000, 25'd0);
    send_word(KIND_FORWARD, 31'd0, 31'd0, '0, '0, 32'd1000, 25'(QUARTER_TURN));
    send_word(KIND_FORWARD, 31'd0, 31'd0, '0, '0, 32'd1000, 25'(HALF_TURN));
    send_word(KIND_FORWARD, 31'd0, 31'd0, '0, '0, 32'd1000, 25'(3 * QUARTER_TURN));
    send_word(KIND_FORWARD, 31'd0, 31'd0, '0, '0, 32'd1000, 25'd23592959);
    send_word(KIND_FORWARD, 31'd0, 31'd0, '0, '0, 32'd1000, 25'h1FFFFFF);
    send_word(KIND_FORWARD, 31'd0, 31'd0, '0, '0, 32'd1000, 25'(FULL_TURN));
    send_word(KIND_FORWARD, 31'h3FFFFFFF, 31'h3FFFFFFF, '0, '0, 32'hFFFFFFFF, 25'd2949120);
    send_word(KIND_FORWARD, 31'h40000000, 31'h40000000, '0, '0, 32'hFFFFFFFF, 25'd14745600);
    send_word(KIND_FORWARD, 31'd12345, -31'sd6789, '0, '0, 32'd0, 25'd1234567);
    send_word(KIND_FORWARD, 31'h7FFFFFFF, 31'h0, 31'h7FFFFFFF, 31'h7FFFFFFF, 32'd1, 25'd1);
  endtask

  task automatic test_random(int count);
    for (int i = 0; i < count; i++) random_word();
  endtask

  task automatic test_backpressure();
    rx_hold = 200;
    test_random(100);
    drain();
    test_random(50);
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    rx_hold = 0;
    south_ref = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    build_atan_table();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    set_reference(1'b1);
    test_directed();
    set_reference(1'b0);
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    test_random(600);
    test_backpressure();
    set_reference(1'b1);
    test_random(600);
    set_reference(1'b0);
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(550);
    drain();
    if (errors == 0) begin
      $display("survey_polar_rect_converter_core_tb: PASS");
    end else begin
      $display("survey_polar_rect_converter_core_tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/spr_pkg.sv
rtl/spr_pre.sv
rtl/spr_cell.sv
rtl/spr_post.sv
rtl/survey_polar_rect_converter_core.sv
tb/survey_polar_rect_converter_core_tb.sv
